// ===== rtl/trdr_pkg.sv =====
// Shared constants, action codes and types of the triangle depth rasterizer.
package trdr_pkg;

  localparam int SCREEN_W = 512;
  localparam int SCREEN_H = 512;
  localparam int X_W      = $clog2(SCREEN_W);
  localparam int Y_W      = $clog2(SCREEN_H);
  localparam int DEPTH    = SCREEN_W * SCREEN_H;
  localparam int ADDR_W   = $clog2(DEPTH);

  // coordinate differences, edge values, multiplier operands
  localparam int DW    = 18;
  localparam int WW    = 37;
  localparam int MA_W  = 19;
  localparam int MB_W  = 33;
  localparam int P_W   = MA_W + MB_W;
  localparam int NUM_W = 64;
  localparam int LO_W  = MA_W - 1;
  localparam int DIV_ITERS = NUM_W;
  localparam int DCNT_W    = $clog2(DIV_ITERS);

  localparam logic signed [31:0] Z_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Z_MIN = 32'sh80000000;

  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/trdr_div.sv =====
// Bit-serial signed divider with truncation and clamp to a 32-bit depth.
module trdr_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [trdr_pkg::NUM_W-1:0] num,
  input  logic signed [trdr_pkg::WW-1:0]   den,
  output trdr_pkg::div_stat_t              stat,
  output logic signed [31:0]               z
);

  logic [trdr_pkg::NUM_W-1:0]  q_r;
  logic [trdr_pkg::WW-1:0]     rem_r;
  logic [trdr_pkg::WW-1:0]     dmag_r;
  logic                        neg_r;
  logic                        run_r;
  logic                        done_r;
  logic [trdr_pkg::DCNT_W-1:0] cnt_r;
  logic [trdr_pkg::WW:0]       trial;
  logic [trdr_pkg::WW:0]       diff;
  logic                        ge;

  assign trial = {rem_r, q_r[trdr_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, dmag_r};
  assign ge    = trial >= {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= num[trdr_pkg::NUM_W-1] ? -num : num;
        dmag_r <= den[trdr_pkg::WW-1] ? -den : den;
        neg_r  <= num[trdr_pkg::NUM_W-1] ^ den[trdr_pkg::WW-1];
        rem_r  <= '0;
        cnt_r  <= '0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? diff[trdr_pkg::WW-1:0] : trial[trdr_pkg::WW-1:0];
        q_r   <= {q_r[trdr_pkg::NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == trdr_pkg::DCNT_W'(trdr_pkg::DIV_ITERS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      if (|q_r[trdr_pkg::NUM_W-1:32] || (q_r[31] && |q_r[30:0])) z = trdr_pkg::Z_MIN;
      else z = -$signed(q_r[31:0]);
    end else begin
      if (|q_r[trdr_pkg::NUM_W-1:31]) z = trdr_pkg::Z_MAX;
      else z = $signed(q_r[31:0]);
    end
  end

  assign stat = {run_r, done_r};

endmodule

// ===== rtl/triangle_depth_rasterizer.sv =====
// Top level of the triangle depth rasterizer: sequencer, shared multiplier, depth store.
//
// One action at a time; busy stays high until its single result strobe (out_valid,
// one cycle, cannot be stalled). After reset and after every clear action a fill pass
// writes all SCREEN_W*SCREEN_H = 262144 entries, one per cycle. A read passes through
// S_RD and S_RDO. A draw first computes the triangle area, then per box pixel the edge
// values on the shared 19x33 multiplier, plus, if covered, the depth numerator on the
// multiplier, the bit-serial divider (one quotient bit per cycle) and a store state.
// The configuration register is only written while the block is idle.
module triangle_depth_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_v0_x,
  input  logic signed [15:0] in_v0_y,
  input  logic signed [31:0] in_v0_z,
  input  logic signed [15:0] in_v1_x,
  input  logic signed [15:0] in_v1_y,
  input  logic signed [31:0] in_v1_z,
  input  logic signed [15:0] in_v2_x,
  input  logic signed [15:0] in_v2_y,
  input  logic signed [31:0] in_v2_z,
  input  logic [8:0]         in_pixel_x,
  input  logic [8:0]         in_pixel_y,
  output logic               out_valid,
  output logic signed [31:0] out_depth_value,
  output logic signed [31:0] out_lowest_depth,
  output logic signed [31:0] out_highest_depth,
  output logic               out_degenerate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_data
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DRN  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_NEXT = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_RDO  = 4'd9;

  localparam logic [3:0] ST_AREA0    = 4'd0;
  localparam logic [3:0] ST_AREA_END = 4'd1;
  localparam logic [3:0] ST_EDGE0    = 4'd2;
  localparam logic [3:0] ST_EDGE_END = 4'd7;
  localparam logic [3:0] ST_NUM0     = 4'd8;
  localparam logic [3:0] ST_NUM_END  = 4'd13;

  localparam logic signed [12:0] XMAX = 13'(trdr_pkg::SCREEN_W - 1);
  localparam logic signed [12:0] YMAX = 13'(trdr_pkg::SCREEN_H - 1);

  logic [3:0]                      state_r;
  logic [3:0]                      step_r;
  logic [3:0]                      pstep_r;
  logic                            pv_r;
  logic signed [15:0]              vx_r [3];
  logic signed [15:0]              vy_r [3];
  logic signed [31:0]              vz_r [3];
  logic signed [trdr_pkg::WW-1:0]  w_r [3];
  logic signed [trdr_pkg::WW-1:0]  area_r;
  logic signed [trdr_pkg::WW-1:0]  tmp_r;
  logic signed [trdr_pkg::NUM_W-1:0] acc_r;
  logic signed [trdr_pkg::P_W-1:0] prod_r;
  logic [trdr_pkg::X_W-1:0]        px_r, bx0_r, bx1_r;
  logic [trdr_pkg::Y_W-1:0]        py_r, by0_r, by1_r;
  logic                            box_empty_r;
  logic                            rd_off_r;
  logic [trdr_pkg::ADDR_W-1:0]     clr_cnt_r;
  logic                            clr_act_r;
  logic signed [31:0]              clear_r;
  logic signed [31:0]              low_r, high_r;
  logic signed [31:0]              depth_value_r;
  logic                            degen_r;
  logic                            out_valid_r;
  logic signed [31:0]              rdata_r;
  logic signed [31:0]              mem [trdr_pkg::DEPTH];

  logic signed [trdr_pkg::MA_W-1:0] a_op;
  logic signed [trdr_pkg::MB_W-1:0] b_op;
  logic signed [trdr_pkg::DW-1:0]   ax, ay, bx, by, qx, qy, sx, sy, d_a, d_b;
  logic signed [trdr_pkg::WW-1:0]   w_sel;
  logic signed [31:0]               z_sel;
  logic signed [trdr_pkg::NUM_W-1:0] prod_ext;
  logic [trdr_pkg::ADDR_W-1:0]      pix_addr, wr_addr;
  logic                             mem_we;
  logic signed [31:0]               mem_wd;
  logic signed [11:0]               fminx, fmaxx, fminy, fmaxy;
  logic                             covered;
  logic                             div_start;
  trdr_pkg::div_stat_t              div_stat;
  logic signed [31:0]               z_div;
  logic                             accept;

  function automatic logic signed [15:0] min3(input logic signed [15:0] a,
      input logic signed [15:0] b, input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [15:0] max3(input logic signed [15:0] a,
      input logic signed [15:0] b, input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [trdr_pkg::DW-1:0] ext16(input logic signed [15:0] v);
    return {{(trdr_pkg::DW-16){v[15]}}, v};
  endfunction

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // bounding box of the incoming triangle, floor to pixel
  assign fminx = 12'(min3(in_v0_x, in_v1_x, in_v2_x) >>> 4);
  assign fmaxx = 12'(max3(in_v0_x, in_v1_x, in_v2_x) >>> 4);
  assign fminy = 12'(min3(in_v0_y, in_v1_y, in_v2_y) >>> 4);
  assign fmaxy = 12'(max3(in_v0_y, in_v1_y, in_v2_y) >>> 4);

  assign sx = {{(trdr_pkg::DW-trdr_pkg::X_W-4){1'b0}}, px_r, 4'b0000};
  assign sy = {{(trdr_pkg::DW-trdr_pkg::Y_W-4){1'b0}}, py_r, 4'b0000};

  // operand select for the shared multiplier
  always_comb begin
    ax = ext16(vx_r[0]); ay = ext16(vy_r[0]);
    bx = ext16(vx_r[1]); by = ext16(vy_r[1]);
    qx = ext16(vx_r[2]); qy = ext16(vy_r[2]);
    unique case (step_r[3:1])
      3'd1: begin
        ax = ext16(vx_r[1]); ay = ext16(vy_r[1]);
        bx = ext16(vx_r[2]); by = ext16(vy_r[2]);
        qx = sx; qy = sy;
      end
      3'd2: begin
        ax = ext16(vx_r[2]); ay = ext16(vy_r[2]);
        bx = ext16(vx_r[0]); by = ext16(vy_r[0]);
        qx = sx; qy = sy;
      end
      3'd3: begin
        ax = ext16(vx_r[0]); ay = ext16(vy_r[0]);
        bx = ext16(vx_r[1]); by = ext16(vy_r[1]);
        qx = sx; qy = sy;
      end
      default: begin
      end
    endcase
    if (step_r[0]) begin
      d_a = by - ay;
      d_b = qx - ax;
    end else begin
      d_a = bx - ax;
      d_b = qy - ay;
    end
    unique case (step_r)
      4'd8, 4'd9:   begin w_sel = w_r[0]; z_sel = vz_r[0]; end
      4'd10, 4'd11: begin w_sel = w_r[1]; z_sel = vz_r[1]; end
      default:      begin w_sel = w_r[2]; z_sel = vz_r[2]; end
    endcase
    if (step_r >= ST_NUM0) begin
      a_op = step_r[0] ? w_sel[trdr_pkg::WW-1:trdr_pkg::LO_W]
                       : {1'b0, w_sel[trdr_pkg::LO_W-1:0]};
      b_op = {z_sel[31], z_sel};
    end else begin
      a_op = {d_a[trdr_pkg::DW-1], d_a};
      b_op = {{(trdr_pkg::MB_W-trdr_pkg::DW){d_b[trdr_pkg::DW-1]}}, d_b};
    end
  end

  assign prod_ext = {{(trdr_pkg::NUM_W-trdr_pkg::P_W){prod_r[trdr_pkg::P_W-1]}}, prod_r};

  always_comb begin
    if (area_r[trdr_pkg::WW-1])
      covered = (w_r[0][trdr_pkg::WW-1] || w_r[0] == '0) &&
                (w_r[1][trdr_pkg::WW-1] || w_r[1] == '0) &&
                (w_r[2][trdr_pkg::WW-1] || w_r[2] == '0);
    else
      covered = !w_r[0][trdr_pkg::WW-1] && !w_r[1][trdr_pkg::WW-1] &&
                !w_r[2][trdr_pkg::WW-1];
  end

  assign div_start = (state_r == S_CHK) && (step_r == ST_NUM_END);

  trdr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (area_r),
    .stat  (div_stat),
    .z     (z_div)
  );

  // depth store
  assign pix_addr = trdr_pkg::ADDR_W'(py_r) * trdr_pkg::ADDR_W'(trdr_pkg::SCREEN_W)
                  + trdr_pkg::ADDR_W'(px_r);
  assign mem_we   = (state_r == S_CLR) || ((state_r == S_WR) && (rdata_r < z_div));
  assign wr_addr  = (state_r == S_CLR) ? clr_cnt_r : pix_addr;
  assign mem_wd   = (state_r == S_CLR) ? clear_r : z_div;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= mem_wd;
    rdata_r <= mem[pix_addr];
  end

  // multiplier and accumulation
  always_ff @(posedge clk) begin
    prod_r  <= a_op * b_op;
    pstep_r <= step_r;
    if (pv_r) begin
      if (pstep_r < ST_NUM0) begin
        if (!pstep_r[0]) begin
          tmp_r <= prod_r[trdr_pkg::WW-1:0];
        end else begin
          unique case (pstep_r[3:1])
            3'd0:    area_r <= tmp_r - prod_r[trdr_pkg::WW-1:0];
            3'd1:    w_r[0] <= tmp_r - prod_r[trdr_pkg::WW-1:0];
            3'd2:    w_r[1] <= tmp_r - prod_r[trdr_pkg::WW-1:0];
            default: w_r[2] <= tmp_r - prod_r[trdr_pkg::WW-1:0];
          endcase
        end
      end else if (pstep_r == ST_NUM0) begin
        acc_r <= prod_ext;
      end else if (pstep_r[0]) begin
        acc_r <= acc_r + (prod_ext <<< trdr_pkg::LO_W);
      end else begin
        acc_r <= acc_r + prod_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vx_r[0] <= in_v0_x; vy_r[0] <= in_v0_y; vz_r[0] <= in_v0_z;
      vx_r[1] <= in_v1_x; vy_r[1] <= in_v1_y; vz_r[1] <= in_v1_z;
      vx_r[2] <= in_v2_x; vy_r[2] <= in_v2_y; vz_r[2] <= in_v2_z;
      bx0_r <= fminx[11] ? '0 : trdr_pkg::X_W'(fminx);
      by0_r <= fminy[11] ? '0 : trdr_pkg::Y_W'(fminy);
      bx1_r <= (13'(fmaxx) > XMAX) ? trdr_pkg::X_W'(XMAX) : trdr_pkg::X_W'(fmaxx);
      by1_r <= (13'(fmaxy) > YMAX) ? trdr_pkg::Y_W'(YMAX) : trdr_pkg::Y_W'(fmaxy);
      box_empty_r <= fmaxx[11] || fmaxy[11] || (13'(fminx) > XMAX) || (13'(fminy) > YMAX);
      rd_off_r <= ({3'b000, in_pixel_x} >= 12'(trdr_pkg::SCREEN_W)) ||
                  ({3'b000, in_pixel_y} >= 12'(trdr_pkg::SCREEN_H));
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_act_r   <= 1'b0;
      clear_r     <= trdr_pkg::Z_MIN;
      low_r       <= trdr_pkg::Z_MAX;
      high_r      <= trdr_pkg::Z_MIN;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      step_r      <= ST_AREA0;
    end else begin
      out_valid_r <= 1'b0;
      pv_r        <= (state_r == S_MUL);
      if (cfg_valid && cfg_ready) clear_r <= cfg_data;
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == trdr_pkg::ADDR_W'(trdr_pkg::DEPTH - 1)) begin
            state_r     <= S_IDLE;
            out_valid_r <= clr_act_r;
          end
        end
        S_IDLE: begin
          if (start) begin
            depth_value_r <= '0;
            degen_r       <= 1'b0;
            unique case (in_action)
              trdr_pkg::ACT_DRAW: begin
                step_r  <= ST_AREA0;
                state_r <= S_MUL;
              end
              trdr_pkg::ACT_READ: begin
                px_r    <= trdr_pkg::X_W'(in_pixel_x);
                py_r    <= trdr_pkg::Y_W'(in_pixel_y);
                state_r <= S_RD;
              end
              trdr_pkg::ACT_CLEAR: begin
                low_r     <= trdr_pkg::Z_MAX;
                high_r    <= trdr_pkg::Z_MIN;
                clr_cnt_r <= '0;
                clr_act_r <= 1'b1;
                state_r   <= S_CLR;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_MUL: begin
          if (step_r == ST_AREA_END || step_r == ST_EDGE_END || step_r == ST_NUM_END)
            state_r <= S_DRN;
          else
            step_r <= step_r + 1'b1;
        end
        S_DRN: state_r <= S_CHK;
        S_CHK: begin
          if (step_r == ST_AREA_END) begin
            if (area_r == '0) begin
              degen_r     <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else if (box_empty_r || bx0_r > bx1_r || by0_r > by1_r) begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              px_r    <= bx0_r;
              py_r    <= by0_r;
              step_r  <= ST_EDGE0;
              state_r <= S_MUL;
            end
          end else if (step_r == ST_EDGE_END) begin
            if (covered) begin
              step_r  <= ST_NUM0;
              state_r <= S_MUL;
            end else begin
              state_r <= S_NEXT;
            end
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: if (div_stat.done) state_r <= S_WR;
        S_WR: begin
          if (z_div < low_r) low_r <= z_div;
          if (z_div > high_r) high_r <= z_div;
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          step_r <= ST_EDGE0;
          if (px_r != bx1_r) begin
            px_r    <= px_r + 1'b1;
            state_r <= S_MUL;
          end else if (py_r != by1_r) begin
            px_r    <= bx0_r;
            py_r    <= py_r + 1'b1;
            state_r <= S_MUL;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_RD: state_r <= S_RDO;
        S_RDO: begin
          depth_value_r <= rd_off_r ? '0 : rdata_r;
          out_valid_r   <= 1'b1;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_depth_value   = depth_value_r;
  assign out_lowest_depth  = low_r;
  assign out_highest_depth = high_r;
  assign out_degenerate    = degen_r;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while busy");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start))) else $error("result beat without work");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action != trdr_pkg::ACT_NONE) |=> busy)
    else $error("accepted action did not raise busy");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (low_r <= high_r) || (low_r == trdr_pkg::Z_MAX && high_r == trdr_pkg::Z_MIN))
    else $error("depth range inverted");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on idle divider");

endmodule

// ===== test/triangle_depth_rasterizer_tb.sv =====
// Testbench of triangle_depth_rasterizer: directed and random actions checked against an own predictor.
module triangle_depth_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         act;
    logic signed [15:0] x0, y0, x1, y1, x2, y2;
    logic signed [31:0] z0, z1, z2;
    logic [8:0]         px, py;
  } action_t;

  typedef struct {
    logic signed [31:0] depth, low, high;
    logic               degen;
  } depth_result_t;

  logic clk, rst_n, start, busy;
  logic [1:0] in_action;
  logic signed [15:0] in_v0_x, in_v0_y, in_v1_x, in_v1_y, in_v2_x, in_v2_y;
  logic signed [31:0] in_v0_z, in_v1_z, in_v2_z;
  logic [8:0] in_pixel_x, in_pixel_y;
  logic out_valid, out_degenerate;
  logic signed [31:0] out_depth_value, out_lowest_depth, out_highest_depth;
  logic cfg_valid, cfg_ready;
  logic signed [31:0] cfg_data;

  triangle_depth_rasterizer dut (.*);

  // predictor state
  int            zbuf [int];
  int            fill_depth;
  int            clear_reg;
  int            range_low, range_high;
  depth_result_t pending_results [$];
  int            mismatches;
  int            cycles;
  bit            no_idle;
  int            near_x, near_y;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                      longint px, longint py);
    return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
  endfunction

  function automatic void wipe_depths();
    zbuf.delete();
    fill_depth = clear_reg;
    range_low  = trdr_pkg::Z_MAX;
    range_high = trdr_pkg::Z_MIN;
  endfunction

  function automatic bit raster_draw(action_t a);
    longint x0, y0, x1, y1, x2, y2, area, bx0, bx1, by0, by1;
    longint w0, w1, w2, num, z;
    int zz, idx, cur;
    x0 = a.x0; y0 = a.y0; x1 = a.x1; y1 = a.y1; x2 = a.x2; y2 = a.y2;
    area = edge_val(x0, y0, x1, y1, x2, y2);
    if (area == 0) return 1'b1;
    bx0 = ((x0 < x1 ? (x0 < x2 ? x0 : x2) : (x1 < x2 ? x1 : x2))) >>> 4;
    bx1 = ((x0 > x1 ? (x0 > x2 ? x0 : x2) : (x1 > x2 ? x1 : x2))) >>> 4;
    by0 = ((y0 < y1 ? (y0 < y2 ? y0 : y2) : (y1 < y2 ? y1 : y2))) >>> 4;
    by1 = ((y0 > y1 ? (y0 > y2 ? y0 : y2) : (y1 > y2 ? y1 : y2))) >>> 4;
    if (bx0 < 0) bx0 = 0;
    if (by0 < 0) by0 = 0;
    if (bx1 > trdr_pkg::SCREEN_W - 1) bx1 = trdr_pkg::SCREEN_W - 1;
    if (by1 > trdr_pkg::SCREEN_H - 1) by1 = trdr_pkg::SCREEN_H - 1;
    for (longint py = by0; py <= by1; py++) begin
      for (longint px = bx0; px <= bx1; px++) begin
        w0 = edge_val(x1, y1, x2, y2, px * 16, py * 16);
        w1 = edge_val(x2, y2, x0, y0, px * 16, py * 16);
        w2 = edge_val(x0, y0, x1, y1, px * 16, py * 16);
        if (area > 0 && (w0 < 0 || w1 < 0 || w2 < 0)) continue;
        if (area < 0 && (w0 > 0 || w1 > 0 || w2 > 0)) continue;
        num = w0 * longint'(a.z0) + w1 * longint'(a.z1) + w2 * longint'(a.z2);
        z = num / area;
        if (z > longint'(trdr_pkg::Z_MAX)) z = trdr_pkg::Z_MAX;
        if (z < longint'(trdr_pkg::Z_MIN)) z = trdr_pkg::Z_MIN;
        zz = int'(z);
        if (zz < range_low) range_low = zz;
        if (zz > range_high) range_high = zz;
        idx = int'(py) * trdr_pkg::SCREEN_W + int'(px);
        cur = zbuf.exists(idx) ? zbuf[idx] : fill_depth;
        if (cur < zz) zbuf[idx] = zz;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_action(action_t a);
    depth_result_t r;
    int idx;
    r.depth = 0;
    r.degen = 1'b0;
    case (a.act)
      trdr_pkg::ACT_DRAW: r.degen = raster_draw(a);
      trdr_pkg::ACT_READ: begin
        if (a.px < trdr_pkg::SCREEN_W && a.py < trdr_pkg::SCREEN_H) begin
          idx = int'(a.py) * trdr_pkg::SCREEN_W + int'(a.px);
          r.depth = zbuf.exists(idx) ? zbuf[idx] : fill_depth;
        end
      end
      trdr_pkg::ACT_CLEAR: wipe_depths();
      default: ;
    endcase
    r.low  = range_low;
    r.high = range_high;
    pending_results.push_back(r);
  endfunction

  task automatic send_action(action_t a);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    in_action = a.act;
    in_v0_x = a.x0; in_v0_y = a.y0; in_v0_z = a.z0;
    in_v1_x = a.x1; in_v1_y = a.y1; in_v1_z = a.z1;
    in_v2_x = a.x2; in_v2_y = a.y2; in_v2_z = a.z2;
    in_pixel_x = a.px; in_pixel_y = a.py;
    start = 1'b1;
    predict_action(a);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_clear_depth(logic signed [31:0] val);
    wait_drained();
    cfg_data  = val;
    cfg_valid = 1'b1;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
    clear_reg = val;
  endtask

  function automatic action_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                     int az, int bz, int cz);
    action_t a;
    a = '{default: '0};
    a.act = trdr_pkg::ACT_DRAW;
    a.x0 = 16'(ax); a.y0 = 16'(ay); a.x1 = 16'(bx); a.y1 = 16'(by);
    a.x2 = 16'(cx); a.y2 = 16'(cy);
    a.z0 = az; a.z1 = bz; a.z2 = cz;
    a.px = 9'($urandom); a.py = 9'($urandom);
    return a;
  endfunction

  function automatic action_t mk_read(int px, int py);
    action_t a;
    a = '{default: '0};
    a.act = trdr_pkg::ACT_READ;
    a.px = 9'(px); a.py = 9'(py);
    a.x0 = 16'($urandom); a.x1 = 16'($urandom); a.x2 = 16'($urandom);
    a.y0 = 16'($urandom); a.y1 = 16'($urandom); a.y2 = 16'($urandom);
    a.z0 = $urandom; a.z1 = $urandom; a.z2 = $urandom;
    return a;
  endfunction

  function automatic action_t mk_plain(logic [1:0] act);
    action_t a;
    a = mk_read($urandom, $urandom);
    a.act = act;
    return a;
  endfunction

  function automatic action_t rand_tri();
    int bx, by, sp, dz;
    action_t a;
    bx = $urandom_range(0, 8480) - 160;
    by = $urandom_range(0, 8480) - 160;
    sp = $urandom_range(0, 3) == 0 ? 40 : 130;
    dz = $urandom;
    a = mk_tri(bx + $urandom_range(0, sp), by + $urandom_range(0, sp),
               bx + $urandom_range(0, sp), by + $urandom_range(0, sp),
               bx + $urandom_range(0, sp), by + $urandom_range(0, sp),
               $urandom, $urandom, $urandom);
    if ($urandom_range(0, 2) == 0) begin
      a.z0 = dz + $urandom_range(0, 65535);
      a.z1 = dz + $urandom_range(0, 65535);
      a.z2 = dz + $urandom_range(0, 65535);
    end
    if ($urandom_range(0, 11) == 0) begin
      a.x2 = 16'(2 * a.x1 - a.x0);
      a.y2 = 16'(2 * a.y1 - a.y0);
    end
    near_x = bx / 16;
    near_y = by / 16;
    return a;
  endfunction

  task automatic test_reset_state();
    send_action(mk_read(0, 0));
    send_action(mk_read(511, 511));
    send_action(mk_plain(trdr_pkg::ACT_NONE));
  endtask

  task automatic test_directed_draws();
    send_action(mk_tri(0, 0, 64, 0, 0, 64, 32'h10000, 32'h20000, 32'h30000));
    send_action(mk_tri(0, 0, 0, 64, 64, 0, 32'h40000, 32'h20000, 32'h30000));
    send_action(mk_tri(16, 16, 48, 48, 80, 80, 5, 6, 7));
    send_action(mk_tri(32, 32, 32, 32, 32, 32, 5, 6, 7));
    send_action(mk_read(0, 0));
    send_action(mk_read(4, 0));
    send_action(mk_read(0, 4));
    send_action(mk_read(1, 1));
    send_action(mk_plain(trdr_pkg::ACT_NONE));
  endtask

  task automatic test_extremes();
    send_action(mk_tri(-32768, -32768, -32768, -100, -200, -32768,
                       32'h7fffffff, 32'h80000000, 0));
    send_action(mk_tri(32767, 32767, 32767, 9000, 9000, 32767, 1, 2, 3));
    send_action(mk_tri(-32768, -32768, 32, 0, 0, 32,
                       32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send_action(mk_tri(8160, 8160, 32767, 8176, 8176, 32767,
                       32'h80000000, 32'h7fffffff, 32'h80000000));
    send_action(mk_tri(-5, -7, 40, 3, 9, 40, 32'hffffffff, 32'h12345678, 32'h87654321));
    send_action(mk_read(0, 1));
    send_action(mk_read(511, 510));
    send_action(mk_read(2, 2));
  endtask

  task automatic test_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) no_idle = $urandom_range(0, 2) == 0;
      pick = $urandom_range(0, 19);
      if (pick < 14) send_action(rand_tri());
      else if (pick < 18)
        send_action(mk_read((near_x + $urandom_range(0, 9)) & 9'h1ff,
                            (near_y + $urandom_range(0, 9)) & 9'h1ff));
      else if (pick < 19) send_action(mk_read($urandom, $urandom));
      else send_action(mk_plain(trdr_pkg::ACT_NONE));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_clear_depth(logic signed [31:0] val, int n);
    write_clear_depth(val);
    send_action(mk_plain(trdr_pkg::ACT_CLEAR));
    send_action(mk_read(7, 9));
    test_random(n);
  endtask

  always @(posedge clk) begin
    depth_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat");
      end else begin
        e = pending_results.pop_front();
        if (out_depth_value !== e.depth || out_lowest_depth !== e.low ||
            out_highest_depth !== e.high || out_degenerate !== e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp depth %0d low %0d high %0d degen %0b, got %0d %0d %0d %0b",
                     e.depth, e.low, e.high, e.degen, out_depth_value,
                     out_lowest_depth, out_highest_depth, out_degenerate);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 20000000) begin
      $display("triangle_depth_rasterizer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    no_idle = 1'b0;
    near_x = 0;
    near_y = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_action = trdr_pkg::ACT_NONE;
    {in_v0_x, in_v0_y, in_v1_x, in_v1_y, in_v2_x, in_v2_y} = '0;
    {in_v0_z, in_v1_z, in_v2_z} = '0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    clear_reg = trdr_pkg::Z_MIN;
    wipe_depths();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_directed_draws();
    test_extremes();
    test_random(50);
    test_clear_depth(trdr_pkg::Z_MAX, 25);
    test_clear_depth($urandom, 25);
    test_clear_depth(trdr_pkg::Z_MIN, 15);
    write_clear_depth(0);
    send_action(mk_read(3, 3));
    wait_drained();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("triangle_depth_rasterizer_tb OK");
    else
      $display("triangle_depth_rasterizer_tb NOT OK");
    $finish;
  end
endmodule
